>>> design/first_fit_page_allocator_top_assert.svh
// Assertion macros for the first-fit page allocator.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FFPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FFPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FFPA_ASSERT(lbl, prop, msg)
`define FFPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> design/ffpa_pkg.sv
// Types and constants of the first-fit page allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffpa_pkg;
  localparam int HEAP_PAGES = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int ID_BITS    = 16;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int IDX_W      = $clog2(HEAP_PAGES);
  localparam int CNT_W      = IDX_W + 1;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_RESIZE = 2'd2;
  localparam logic [1:0] REQ_SPARE  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        has_block;
    logic [9:0]  start_page;
    logic [31:0] byte_size;
  } ffpa_req_t;

  typedef struct packed {
    logic        status;
    logic [9:0]  result_page;
    logic [10:0] page_count;
    logic        moved;
    logic [10:0] old_pages;
  } ffpa_res_t;
endpackage
`default_nettype wire

>>> design/first_fit_page_allocator_top.sv
// First-fit page allocator: page map in one synchronous RAM, sequenced scans.
//
//  channel  ports                      handshake
//  request  start, busy, in_req        beat taken when start && !busy
//  result   out_valid, out_res         one-cycle strobe, cannot be stalled
//
// After reset a clearing pass writes zero to every page map entry, busy high.
// Each request runs one or more scans of the page map, one entry per cycle through
// the RAM read port; a resize that moves also stamps its new block and clears the old.
// Results leave from an output register; no stall from the receiver.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_page_allocator_top
  import ffpa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire ffpa_req_t in_req,
  output logic           out_valid,
  output ffpa_res_t      out_res
);
`include "first_fit_page_allocator_top_assert.svh"

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_OWN   = 4'd2;
  localparam logic [3:0] S_RUN   = 4'd3;
  localparam logic [3:0] S_CLR   = 4'd4;
  localparam logic [3:0] S_GCHK  = 4'd5;
  localparam logic [3:0] S_GWR   = 4'd6;
  localparam logic [3:0] S_FIT   = 4'd7;
  localparam logic [3:0] S_STAMP = 4'd8;

  localparam logic [CNT_W-1:0] HEAP_CNT = CNT_W'(HEAP_PAGES);

  logic [ID_BITS-1:0] mem [HEAP_PAGES];
  logic [ID_BITS-1:0] rdata;
  logic [IDX_W-1:0]   raddr, waddr;
  logic [ID_BITS-1:0] wdata;
  logic               mem_we;

  logic [3:0]         state_r, state_nxt;
  ffpa_req_t          req_r, req_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt, size_r, size_nxt, run_r, run_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt, end_r, end_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt, at_r, at_nxt;
  logic               pv_r, pv_nxt, rsz_r, rsz_nxt, moved_r, moved_nxt;
  logic [ID_BITS-1:0] cur_r, cur_nxt, nid_r, nid_nxt, nid_inc;
  logic               ov_r, ov_nxt;
  ffpa_res_t          res_r, res_nxt, emit_res;
  logic               emit, go_alloc, hit;
  logic [32:0]        pg_raw;
  logic [CNT_W-1:0]   pages, n_use;
  logic [CNT_W-1:0]   s_ext;
  logic [CNT_W:0]     s_plus_n;
  logic [CNT_W-1:0]   fit_at;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign pg_raw = {1'b0, in_req.byte_size >> PAGE_SHIFT}
                + 33'(|in_req.byte_size[PAGE_SHIFT-1:0]);
  assign pages  = (pg_raw > 33'(HEAP_PAGES)) ? (HEAP_CNT + 1'b1) : pg_raw[CNT_W-1:0];
  assign n_use  = (state_r == S_IDLE) ? pages : n_r;
  assign s_ext  = {1'b0, req_r.start_page};
  assign s_plus_n = {1'b0, s_ext} + {1'b0, n_r};
  assign fit_at = {1'b0, pos_r} + 1'b1 - n_r;
  assign hit    = pv_r && (rdata == cur_r);
  assign nid_inc = (nid_r + 1'b1 == '0) ? ID_BITS'(1) : nid_r + 1'b1;

  function automatic ffpa_res_t mk(input logic st, input logic [IDX_W-1:0] pg,
                                   input logic [CNT_W-1:0] cnt, input logic mv,
                                   input logic [CNT_W-1:0] oldp);
    ffpa_res_t r;
    r.status      = st;
    r.result_page = pg;
    r.page_count  = cnt;
    r.moved       = mv;
    r.old_pages   = oldp;
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    n_nxt     = n_r;
    size_nxt  = size_r;
    run_nxt   = run_r;
    ptr_nxt   = ptr_r;
    end_nxt   = end_r;
    pos_nxt   = pos_r;
    at_nxt    = at_r;
    pv_nxt    = 1'b0;
    rsz_nxt   = rsz_r;
    moved_nxt = moved_r;
    cur_nxt   = cur_r;
    nid_nxt   = nid_r;
    res_nxt   = res_r;
    ov_nxt    = 1'b0;
    raddr     = ptr_r[IDX_W-1:0];
    waddr     = ptr_r[IDX_W-1:0];
    wdata     = '0;
    mem_we    = 1'b0;
    emit      = 1'b0;
    emit_res  = '0;
    go_alloc  = 1'b0;

    case (state_r)
      S_INIT: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r + 1'b1 == HEAP_CNT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          n_nxt     = pages;
          rsz_nxt   = 1'b0;
          moved_nxt = 1'b0;
          if (in_req.req_type == REQ_FREE ||
              (in_req.req_type == REQ_RESIZE && in_req.has_block)) begin
            raddr     = in_req.start_page;
            state_nxt = S_OWN;
          end else begin
            go_alloc = 1'b1;
          end
        end
      end
      S_OWN: begin
        cur_nxt = rdata;
        if (rdata == '0) begin
          if (req_r.req_type == REQ_FREE) begin
            emit     = 1'b1;
            emit_res = mk(1'b0, req_r.start_page, '0, 1'b0, '0);
          end else begin
            go_alloc = 1'b1;
          end
        end else begin
          rsz_nxt   = (req_r.req_type != REQ_FREE);
          ptr_nxt   = s_ext + 1'b1;
          size_nxt  = CNT_W'(1);
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        size_nxt = size_r + CNT_W'(hit);
        if ((!pv_r || hit) && ptr_r < HEAP_CNT) begin
          pv_nxt  = 1'b1;
          pos_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt = ptr_r + 1'b1;
        end else if (req_r.req_type == REQ_FREE || n_r == '0) begin
          state_nxt = S_CLR;
          ptr_nxt   = s_ext;
          end_nxt   = s_ext + size_nxt;
        end else if (n_r == size_nxt) begin
          emit     = 1'b1;
          emit_res = mk(1'b0, req_r.start_page, '0, 1'b0, size_nxt);
        end else if (n_r > size_nxt && s_plus_n <= (CNT_W + 1)'(HEAP_PAGES)) begin
          state_nxt = S_GCHK;
          ptr_nxt   = s_ext + size_nxt;
          end_nxt   = s_plus_n[CNT_W-1:0];
        end else begin
          go_alloc = 1'b1;
        end
      end
      S_GCHK: begin
        if (pv_r && rdata != '0) begin
          go_alloc = 1'b1;
        end else if (ptr_r != end_r) begin
          pv_nxt  = 1'b1;
          pos_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          state_nxt = S_GWR;
          ptr_nxt   = s_ext + size_r;
        end
      end
      S_GWR: begin
        mem_we  = 1'b1;
        wdata   = cur_r;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r + 1'b1 == end_r) begin
          emit     = 1'b1;
          emit_res = mk(1'b0, req_r.start_page, n_r - size_r, 1'b0, size_r);
        end
      end
      S_FIT: begin
        run_nxt = run_r;
        if (pv_r && rdata == '0 && n_r == '0) begin
          nid_nxt  = nid_inc;
          emit     = 1'b1;
          emit_res = mk(1'b0, pos_r, '0, 1'b0, '0);
        end else if (pv_r && rdata == '0 && run_r + 1'b1 == n_r) begin
          at_nxt    = fit_at[IDX_W-1:0];
          ptr_nxt   = fit_at;
          end_nxt   = fit_at + n_r;
          state_nxt = S_STAMP;
        end else begin
          if (pv_r) begin
            run_nxt = (rdata == '0) ? run_r + 1'b1 : '0;
          end
          if (ptr_r < HEAP_CNT) begin
            pv_nxt  = 1'b1;
            pos_nxt = ptr_r[IDX_W-1:0];
            ptr_nxt = ptr_r + 1'b1;
          end else begin
            emit     = 1'b1;
            emit_res = rsz_r ? mk(1'b1, req_r.start_page, '0, 1'b0, size_r)
                             : mk(1'b1, '0, '0, 1'b0, '0);
          end
        end
      end
      S_STAMP: begin
        mem_we  = 1'b1;
        wdata   = nid_r;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r + 1'b1 == end_r) begin
          nid_nxt = nid_inc;
          if (rsz_r) begin
            moved_nxt = 1'b1;
            state_nxt = S_CLR;
            ptr_nxt   = s_ext;
            end_nxt   = s_ext + size_r;
          end else begin
            emit     = 1'b1;
            emit_res = mk(1'b0, at_r, n_r, 1'b0, '0);
          end
        end
      end
      S_CLR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r + 1'b1 == end_r) begin
          emit = 1'b1;
          if (req_r.req_type == REQ_FREE) begin
            emit_res = mk(1'b0, req_r.start_page, size_r, 1'b0, '0);
          end else if (moved_r) begin
            emit_res = mk(1'b0, at_r, n_r, 1'b1, size_r);
          end else begin
            emit_res = mk(1'b0, req_r.start_page, size_r, 1'b0, size_r);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go_alloc) begin
      if (n_use > HEAP_CNT) begin
        emit     = 1'b1;
        emit_res = rsz_nxt ? mk(1'b1, req_r.start_page, '0, 1'b0, size_nxt)
                           : mk(1'b1, '0, '0, 1'b0, '0);
      end else begin
        state_nxt = S_FIT;
        ptr_nxt   = '0;
        run_nxt   = '0;
        pv_nxt    = 1'b0;
      end
    end
    if (emit) begin
      ov_nxt    = 1'b1;
      res_nxt   = emit_res;
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ptr_r   <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
      nid_r   <= ID_BITS'(1);
      rsz_r   <= 1'b0;
      moved_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
      nid_r   <= nid_nxt;
      rsz_r   <= rsz_nxt;
      moved_r <= moved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    n_r    <= n_nxt;
    size_r <= size_nxt;
    run_r  <= run_nxt;
    end_r  <= end_nxt;
    pos_r  <= pos_nxt;
    at_r   <= at_nxt;
    cur_r  <= cur_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_res   = res_r;

  `FFPA_ASSERT(a_result_idle, out_valid |-> state_r == S_IDLE, "result while busy")
  `FFPA_ASSERT(a_accept_acts, (start && !busy) |=> (busy || out_valid), "beat dropped")
  `FFPA_ASSERT(a_id_nonzero, nid_r != '0, "allocation id is zero")
  `FFPA_ASSERT(a_write_busy, mem_we |-> state_r != S_IDLE, "page map written when idle")

endmodule
`default_nettype wire

>>> tb/first_fit_page_allocator_top_test.sv
// Self-checking testbench of the first-fit page allocator: directed and random requests.
`timescale 1ns / 1ps
module first_fit_page_allocator_top_test;
  import ffpa_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  ffpa_req_t in_req = '0;
  logic      out_valid;
  ffpa_res_t out_res;

  first_fit_page_allocator_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [15:0] owner_map [HEAP_PAGES];
  logic [15:0] fresh_id;
  ffpa_res_t   pending_res [$];
  ffpa_res_t   last_pred;
  int          n_bad = 0;
  int          n_sent = 0;

  function automatic int pages_needed(logic [31:0] bytes);
    longint unsigned n;
    n = ({32'd0, bytes} + PAGE_BYTES - 1) / PAGE_BYTES;
    if (n > HEAP_PAGES) n = HEAP_PAGES + 1;
    return int'(n);
  endfunction

  function automatic int find_first_fit(int n);
    int run;
    run = 0;
    for (int i = 0; i < HEAP_PAGES; i++) begin
      if (owner_map[i] == 16'd0) begin
        if (n == 0) return i;
        run++;
        if (run == n) return i + 1 - n;
      end else begin
        run = 0;
      end
    end
    return HEAP_PAGES;
  endfunction

  function automatic int owned_run(int s, logic [15:0] id);
    int i;
    i = s;
    while (i < HEAP_PAGES && owner_map[i] == id) i++;
    return i - s;
  endfunction

  function automatic bit stamp_block(int n, output int at);
    int s;
    at = 0;
    if (n > HEAP_PAGES) return 1'b0;
    s = find_first_fit(n);
    if (s >= HEAP_PAGES) return 1'b0;
    for (int k = 0; k < n; k++) owner_map[s + k] = fresh_id;
    fresh_id = fresh_id + 16'd1;
    if (fresh_id == 16'd0) fresh_id = 16'd1;
    at = s;
    return 1'b1;
  endfunction

  function automatic ffpa_res_t mk_res(bit st, int pg, int cnt, bit mv, int oldp);
    ffpa_res_t r;
    r.status = st;
    r.result_page = pg[9:0];
    r.page_count = cnt[10:0];
    r.moved = mv;
    r.old_pages = oldp[10:0];
    return r;
  endfunction

  function automatic ffpa_res_t allocator_predict(ffpa_req_t q);
    int n, s, at, size, add, e;
    logic [15:0] cur;
    bit held, room;
    n = pages_needed(q.byte_size);
    s = q.start_page;
    held = owner_map[s] != 16'd0;
    if (q.req_type == REQ_FREE) begin
      if (!held) return mk_res(0, s, 0, 0, 0);
      cur = owner_map[s];
      size = owned_run(s, cur);
      for (int k = 0; k < size; k++) owner_map[s + k] = 16'd0;
      return mk_res(0, s, size, 0, 0);
    end
    if (q.req_type != REQ_RESIZE || !q.has_block || !held) begin
      if (stamp_block(n, at)) return mk_res(0, at, n, 0, 0);
      return mk_res(1, 0, 0, 0, 0);
    end
    cur = owner_map[s];
    size = owned_run(s, cur);
    if (n == 0) begin
      for (int k = 0; k < size; k++) owner_map[s + k] = 16'd0;
      return mk_res(0, s, size, 0, size);
    end
    if (n == size) return mk_res(0, s, 0, 0, size);
    if (n > size) begin
      e = s + size;
      add = n - size;
      room = e + add <= HEAP_PAGES;
      for (int k = 0; room && k < add; k++)
        if (owner_map[e + k] != 16'd0) room = 1'b0;
      if (room) begin
        for (int k = 0; k < add; k++) owner_map[e + k] = cur;
        return mk_res(0, s, add, 0, size);
      end
    end
    if (!stamp_block(n, at)) return mk_res(1, s, 0, 0, size);
    for (int k = 0; k < size; k++)
      if (owner_map[s + k] == cur) owner_map[s + k] = 16'd0;
    return mk_res(0, at, n, 1, size);
  endfunction

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    start <= 1'b0;
    if (r < 92) repeat ($urandom_range(1, 4)) @(posedge clk);
    else repeat ($urandom_range(20, 200)) @(posedge clk);
  endtask

  task automatic send_req(logic [1:0] kind, bit hb, int pg, logic [31:0] bytes);
    ffpa_req_t q;
    q.req_type = kind;
    q.has_block = hb;
    q.start_page = pg[9:0];
    q.byte_size = bytes;
    start <= 1'b1;
    in_req <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    last_pred = allocator_predict(q);
    pending_res.push_back(last_pred);
    n_sent++;
    idle_gap();
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_res.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result beat %h", out_res);
      end else begin
        ffpa_res_t x;
        x = pending_res.pop_front();
        if (x.status !== out_res.status || x.result_page !== out_res.result_page ||
            x.page_count !== out_res.page_count || x.moved !== out_res.moved ||
            x.old_pages !== out_res.old_pages) begin
          n_bad++;
          if (n_bad <= 10) $display("result beat: expected %h got %h", x, out_res);
        end
      end
    end
  end

  int live_pages [$];

  function automatic int pick_page();
    if (live_pages.size() != 0 && $urandom_range(0, 3) != 0)
      return live_pages[$urandom_range(0, live_pages.size() - 1)];
    return $urandom_range(0, HEAP_PAGES - 1);
  endfunction

  task automatic test_directed();
    send_req(REQ_ALLOC, 0, 0, 32'd0);
    send_req(REQ_ALLOC, 0, 0, 32'd1);
    send_req(REQ_ALLOC, 0, 0, 32'd4096);
    send_req(REQ_ALLOC, 0, 0, 32'd4097);
    send_req(REQ_ALLOC, 0, 0, 32'hFFFF_FFFF);
    send_req(REQ_SPARE, 1, 1023, 32'd8192);
    send_req(REQ_FREE, 0, 1, 32'd0);
    send_req(REQ_FREE, 0, 1, 32'd0);
    send_req(REQ_RESIZE, 0, 5, 32'd100);
    send_req(REQ_RESIZE, 1, 2, 32'd4096);
    send_req(REQ_RESIZE, 1, 2, 32'd20000);
    send_req(REQ_RESIZE, 1, 2, 32'd4096);
    send_req(REQ_RESIZE, 1, 900, 32'd4096);
    send_req(REQ_RESIZE, 1, 0, 32'd0);
    send_req(REQ_ALLOC, 0, 0, 32'd4194304);
    send_req(REQ_ALLOC, 0, 0, 32'd0);
    send_req(REQ_RESIZE, 1, 0, 32'd8192);
    send_req(REQ_FREE, 1, 0, 32'hFFFF_FFFF);
    send_req(REQ_ALLOC, 0, 0, 32'd4194304);
    send_req(REQ_FREE, 0, 0, 32'd0);
    drain_results();
  endtask

  task automatic test_random(int count);
    int r, pg;
    logic [31:0] bytes;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: bytes = $urandom();
        1: bytes = 32'd0;
        default: bytes = $urandom_range(1, 40 * PAGE_BYTES);
      endcase
      pg = pick_page();
      if (r < 40) begin
        send_req(REQ_ALLOC, 1'($urandom_range(0, 1)), $urandom_range(0, 1023), bytes);
        if (last_pred.status == 1'b0)
          live_pages.push_back(last_pred.result_page);
      end else if (r < 70) begin
        send_req(REQ_FREE, 1'($urandom_range(0, 1)), pg, $urandom());
      end else if (r < 97) begin
        send_req(REQ_RESIZE, $urandom_range(0, 5) != 0, pg, bytes);
        if (last_pred.status == 1'b0)
          live_pages.push_back(last_pred.result_page);
      end else begin
        send_req(REQ_SPARE, 1'($urandom_range(0, 1)), $urandom_range(0, 1023), bytes);
      end
      if (live_pages.size() > 40) void'(live_pages.pop_front());
      if (i == count / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    fresh_id = 16'd1;
    foreach (owner_map[i]) owner_map[i] = 16'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(270);
    repeat (50) @(posedge clk);
    if (n_bad == 0 && pending_res.size() == 0)
      $display("first_fit_page_allocator_top: match");
    else
      $display("first_fit_page_allocator_top: mismatch");
    $finish;
  end

  initial begin
    #20000000;
    $display("first_fit_page_allocator_top: mismatch");
    $finish;
  end
endmodule
